/* hw/rtl/fwft_pkg.sv */
// types and constants shared by the flash wear and fault tracker
package fwft_pkg;

  localparam int BLOCK_INDEX_W = 10;
  localparam int PAGE_INDEX_W  = 16;
  localparam int COUNT_W       = 24;
  localparam int CFG_W         = 24;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_REGS      = 7;

  // largest address spaces the item fields can reach
  localparam int BLOCK_SPACE = 1 << BLOCK_INDEX_W;
  localparam int PAGE_SPACE  = 1 << PAGE_INDEX_W;

  typedef enum logic [1:0] {
    CMD_ERASE   = 2'd0,
    CMD_PROGRAM = 2'd1,
    CMD_READ    = 2'd2,
    CMD_COPY    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_FAIL    = 2'd1,
    STATUS_INVALID = 2'd2
  } status_t;

  localparam logic [1:0] GRADE_CLEAN = 2'd0;
  localparam logic [1:0] GRADE_LOW   = 2'd1;
  localparam logic [1:0] GRADE_HIGH  = 2'd2;
  localparam logic [1:0] GRADE_FAIL  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_ERASE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PROG    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRAVE_PAGE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ECC_MID     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ECC_HIGH    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ECC_FAIL    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_POWER_CUT   = 3'd6;

  typedef struct packed {
    cmd_t                     command;
    logic [BLOCK_INDEX_W-1:0] block_index;
    logic [PAGE_INDEX_W-1:0]  page_index;
  } fwft_op_t;

  typedef struct packed {
    status_t              status;
    logic                 crash_fired;
    logic [1:0]           ecc_grade;
    logic [COUNT_W-1:0]   wear_count;
    logic [COUNT_W-1:0]   page_read_count;
  } fwft_result_t;

  // control from the sequencer to the counter memories
  typedef struct packed {
    logic rd_en;
    logic blk_we;
    logic pg_we;
  } fwft_mem_ctl_t;

endpackage

/* hw/rtl/fwft_wear_mem.sv */
// counter memories for erase, program and read counts with clearing pass
module fwft_wear_mem import fwft_pkg::*; #(
  parameter int BLK_DEPTH  = 1024,
  parameter int PG_DEPTH   = 65536,
  parameter int COUNT_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  fwft_mem_ctl_t         ctl,
  input  logic [(BLK_DEPTH > 1 ? $clog2(BLK_DEPTH) : 1)-1:0] rd_blk_addr,
  input  logic [(PG_DEPTH > 1 ? $clog2(PG_DEPTH) : 1)-1:0]   rd_pg_addr,
  input  logic [(BLK_DEPTH > 1 ? $clog2(BLK_DEPTH) : 1)-1:0] wr_blk_addr,
  input  logic [(PG_DEPTH > 1 ? $clog2(PG_DEPTH) : 1)-1:0]   wr_pg_addr,
  input  logic [COUNT_BITS-1:0] blk_wdata,
  input  logic [COUNT_BITS-1:0] pg_prog_wdata,
  input  logic [COUNT_BITS-1:0] pg_read_wdata,
  output logic [COUNT_BITS-1:0] blk_rdata,
  output logic [COUNT_BITS-1:0] pg_prog_rdata,
  output logic [COUNT_BITS-1:0] pg_read_rdata,
  output logic                  clearing
);

  localparam int BLK_AW    = BLK_DEPTH > 1 ? $clog2(BLK_DEPTH) : 1;
  localparam int PG_AW     = PG_DEPTH > 1 ? $clog2(PG_DEPTH) : 1;
  localparam int CLR_DEPTH = BLK_DEPTH > PG_DEPTH ? BLK_DEPTH : PG_DEPTH;
  localparam int CLR_AW    = CLR_DEPTH > 1 ? $clog2(CLR_DEPTH) : 1;

  logic [COUNT_BITS-1:0]   blk_mem [BLK_DEPTH];
  logic [2*COUNT_BITS-1:0] pg_mem  [PG_DEPTH];
  logic [2*COUNT_BITS-1:0] pg_q;
  logic [CLR_AW-1:0]       clr_cnt;
  logic                    clr_blk_en;
  logic                    clr_pg_en;

  assign clr_blk_en = clearing && ({1'b0, clr_cnt} < (CLR_AW+1)'(BLK_DEPTH));
  assign clr_pg_en  = clearing && ({1'b0, clr_cnt} < (CLR_AW+1)'(PG_DEPTH));

  // sweep every entry to zero after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      if (clr_cnt == CLR_AW'(CLR_DEPTH - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_blk_en) begin
      blk_mem[clr_cnt[BLK_AW-1:0]] <= '0;
    end else if (!clearing && ctl.blk_we) begin
      blk_mem[wr_blk_addr] <= blk_wdata;
    end
    if (ctl.rd_en) begin
      blk_rdata <= blk_mem[rd_blk_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (clr_pg_en) begin
      pg_mem[clr_cnt[PG_AW-1:0]] <= '0;
    end else if (!clearing && ctl.pg_we) begin
      pg_mem[wr_pg_addr] <= {pg_prog_wdata, pg_read_wdata};
    end
    if (ctl.rd_en) begin
      pg_q <= pg_mem[rd_pg_addr];
    end
  end

  assign pg_prog_rdata = pg_q[2*COUNT_BITS-1:COUNT_BITS];
  assign pg_read_rdata = pg_q[COUNT_BITS-1:0];

endmodule

/* hw/rtl/flash_wear_fault_tracker.sv */
// flash wear and fault tracker: sequencer, crash logic and configuration
// result: the strobe (done) is registered from the execute state that follows the taken start transfer
// items: busy stays high through execute, so a new item waits for the read-modify-write of the counter memories
// reset: clears configuration, operation count and crash flag, then sweeps the counter
//   memories with busy high; config writes taken throughout; results cannot be stalled
module flash_wear_fault_tracker import fwft_pkg::*; #(
  parameter int BLOCKS      = 1024,
  parameter int BLOCK_PAGES = 64,
  parameter int COUNT_BITS  = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  fwft_op_t             op,
  output logic                 done,
  output fwft_result_t         result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // only the first 2^10 blocks and 2^16 pages can ever be addressed
  localparam int PAGE_COUNT = BLOCKS * BLOCK_PAGES;
  localparam int BLK_DEPTH  = BLOCKS < BLOCK_SPACE ? BLOCKS : BLOCK_SPACE;
  localparam int PG_DEPTH   = PAGE_COUNT < PAGE_SPACE ? PAGE_COUNT : PAGE_SPACE;
  localparam int BLK_AW     = BLK_DEPTH > 1 ? $clog2(BLK_DEPTH) : 1;
  localparam int PG_AW      = PG_DEPTH > 1 ? $clog2(PG_DEPTH) : 1;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  // configuration registers
  logic [CFG_W-1:0] max_erase;
  logic [CFG_W-1:0] max_prog;
  logic [CFG_W-1:0] grave_page;
  logic [CFG_W-1:0] ecc_mid;
  logic [CFG_W-1:0] ecc_high;
  logic [CFG_W-1:0] ecc_fail;
  logic [CFG_W-1:0] power_cut;

  // tracker state outside the memories
  logic [COUNT_BITS-1:0] op_count;
  logic [COUNT_BITS-1:0] op_count_next;
  logic                  crashed;
  logic                  crashed_next;

  fwft_op_t      op_q;      // item held for the execute cycle
  fwft_result_t  result_next;
  fwft_mem_ctl_t mem_ctl;

  logic                  accept;
  logic                  clearing;
  logic [COUNT_BITS-1:0] blk_rdata;
  logic [COUNT_BITS-1:0] pg_prog_rdata;
  logic [COUNT_BITS-1:0] pg_read_rdata;
  logic [COUNT_BITS-1:0] blk_wdata;
  logic [COUNT_BITS-1:0] pg_prog_wdata;
  logic [COUNT_BITS-1:0] pg_read_wdata;
  logic                  blk_oor;
  logic                  pg_oor;
  logic                  crash_hit;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  // counts and thresholds meet on a common 32-bit scale
  function automatic logic [31:0] cnt32(input logic [COUNT_BITS-1:0] v);
    return 32'(v);
  endfunction

  function automatic logic [COUNT_W-1:0] to_field(input logic [COUNT_BITS-1:0] v);
    return COUNT_W'(32'(v));
  endfunction

  assign accept    = start && !busy;
  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------------------
  // configuration port: writes beyond the register list are dropped
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      max_erase  <= '0;
      max_prog   <= '0;
      grave_page <= '0;
      ecc_mid    <= '0;
      ecc_high   <= '0;
      ecc_fail   <= '0;
      power_cut  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MAX_ERASE:  max_erase  <= cfg_data;
        REG_MAX_PROG:   max_prog   <= cfg_data;
        REG_GRAVE_PAGE: grave_page <= cfg_data;
        REG_ECC_MID:    ecc_mid    <= cfg_data;
        REG_ECC_HIGH:   ecc_high   <= cfg_data;
        REG_ECC_FAIL:   ecc_fail   <= cfg_data;
        REG_POWER_CUT:  power_cut  <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer: clear sweep, then idle / execute; a new item is only taken in idle, never during execute cycles
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (!clearing) state_next = ST_IDLE;
      ST_IDLE:  if (accept) state_next = ST_EXEC;
      ST_EXEC:  state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      done     <= 1'b0;
      op_count <= '0;
      crashed  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_EXEC);
      if (state == ST_EXEC) begin
        op_count <= op_count_next;
        crashed  <= crashed_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q <= op;
    end
    if (state == ST_EXEC) begin
      result <= result_next;
    end
  end

  // ---------------------------------------------------------------------------
  // execute cycle: memory data is back, work out the result and write back
  // ---------------------------------------------------------------------------
  assign blk_oor = 32'(op_q.block_index) >= 32'(BLOCKS);
  assign pg_oor  = 32'(op_q.page_index) >= 32'(PAGE_COUNT);

  always_comb begin
    op_count_next = op_count;
    crashed_next  = crashed;
    crash_hit     = 1'b0;
    result_next   = '0;
    mem_ctl       = '0;
    blk_wdata     = sat_inc(blk_rdata);
    pg_prog_wdata = pg_prog_rdata;
    pg_read_wdata = pg_read_rdata;

    mem_ctl.rd_en = accept;

    // erase and program advance the operation count; crash check follows it
    if (!crashed && (op_q.command == CMD_ERASE || op_q.command == CMD_PROGRAM)) begin
      op_count_next = sat_inc(op_count);
      crash_hit     = (power_cut != '0) &&
                      (cnt32(op_count_next) >= 32'(power_cut));
    end

    if (crashed) begin
      result_next.status = STATUS_INVALID;
    end else begin
      case (op_q.command)
        CMD_ERASE: begin
          if (crash_hit) begin
            result_next.status      = STATUS_FAIL;
            result_next.crash_fired = 1'b1;
            crashed_next            = 1'b1;
          end else if (blk_oor) begin
            result_next.status = STATUS_FAIL;
          end else if (max_erase != '0) begin
            // count is stored even once past the limit
            mem_ctl.blk_we         = (state == ST_EXEC);
            result_next.wear_count = to_field(blk_wdata);
            if (cnt32(blk_wdata) > 32'(max_erase)) begin
              result_next.status = STATUS_FAIL;
            end
          end else begin
            // erase counting off: report the count as it stands
            result_next.wear_count = to_field(blk_rdata);
          end
        end
        CMD_PROGRAM: begin
          if (crash_hit) begin
            result_next.status      = STATUS_FAIL;
            result_next.crash_fired = 1'b1;
            crashed_next            = 1'b1;
          end else if (pg_oor) begin
            result_next.status = STATUS_FAIL;
          end else begin
            pg_prog_wdata          = sat_inc(pg_prog_rdata);
            mem_ctl.pg_we          = (state == ST_EXEC);
            result_next.wear_count = to_field(pg_prog_wdata);
            if (max_prog != '0 && cnt32(pg_prog_wdata) > 32'(max_prog)) begin
              result_next.status = STATUS_FAIL;
            end
          end
        end
        CMD_READ: begin
          if (pg_oor) begin
            result_next.status = STATUS_FAIL;
          end else begin
            pg_read_wdata               = sat_inc(pg_read_rdata);
            mem_ctl.pg_we               = (state == ST_EXEC);
            result_next.wear_count      = to_field(pg_prog_rdata);
            result_next.page_read_count = to_field(pg_read_wdata);
            // worn-out page first, then read disturb grades from worst down
            if (grave_page != '0 && cnt32(pg_prog_rdata) > 32'(grave_page)) begin
              result_next.ecc_grade = GRADE_FAIL;
            end else if (ecc_fail != '0 && cnt32(pg_read_wdata) >= 32'(ecc_fail)) begin
              result_next.ecc_grade = GRADE_FAIL;
            end else if (ecc_high != '0 && cnt32(pg_read_wdata) >= 32'(ecc_high)) begin
              result_next.ecc_grade = GRADE_HIGH;
            end else if (ecc_mid != '0 && cnt32(pg_read_wdata) >= 32'(ecc_mid)) begin
              result_next.ecc_grade = GRADE_LOW;
            end else begin
              result_next.ecc_grade = GRADE_CLEAN;
            end
          end
        end
        CMD_COPY: begin
          result_next.status = STATUS_OK;
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // counter memories; reads issued on the start transfer, written back in execute
  // ---------------------------------------------------------------------------
  fwft_wear_mem #(
    .BLK_DEPTH  (BLK_DEPTH),
    .PG_DEPTH   (PG_DEPTH),
    .COUNT_BITS (COUNT_BITS)
  ) u_wear_mem (
    .clk           (clk),
    .rst           (rst),
    .ctl           (mem_ctl),
    .rd_blk_addr   (op.block_index[BLK_AW-1:0]),
    .rd_pg_addr    (op.page_index[PG_AW-1:0]),
    .wr_blk_addr   (op_q.block_index[BLK_AW-1:0]),
    .wr_pg_addr    (op_q.page_index[PG_AW-1:0]),
    .blk_wdata     (blk_wdata),
    .pg_prog_wdata (pg_prog_wdata),
    .pg_read_wdata (pg_read_wdata),
    .blk_rdata     (blk_rdata),
    .pg_prog_rdata (pg_prog_rdata),
    .pg_read_rdata (pg_read_rdata),
    .clearing      (clearing)
  );

endmodule

/* hw/rtl/fwft_checker.sv */
// port-level checks for the flash wear and fault tracker, bound to the top level
module fwft_checker import fwft_pkg::*; (
  input logic         clk,
  input logic         rst,
  input logic         start,
  input logic         busy,
  input logic         done,
  input fwft_result_t result
);

  // a taken item keeps the block busy for its execute cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("block not busy after start transfer");

  // every taken item gives its result strobe, registered from its execute state
  a_accept_done: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> ##1 done)
    else $error("result strobe missing two cycles after start transfer");

  // results never arrive in adjacent cycles
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  // the crash step always reports a failure
  a_crash_fail: assert property (@(posedge clk) disable iff (rst)
    done && result.crash_fired |-> result.status == STATUS_FAIL)
    else $error("crash step without failed status");

  // refused commands carry nothing else
  a_invalid_empty: assert property (@(posedge clk) disable iff (rst)
    done && result.status == STATUS_INVALID |->
      !result.crash_fired && result.ecc_grade == GRADE_CLEAN &&
      result.wear_count == '0 && result.page_read_count == '0)
    else $error("invalid-state result with non-zero fields");

endmodule

bind flash_wear_fault_tracker fwft_checker u_fwft_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

/* verif/fwft_tracker_check.sv */
// checker for the flash wear and fault tracker: predicts every result and compares it
module fwft_tracker_check import fwft_pkg::*; #(
  parameter int BLOCKS      = 1024,
  parameter int BLOCK_PAGES = 64,
  parameter int COUNT_BITS  = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  fwft_op_t             op,
  input  logic                 done,
  input  fwft_result_t         result,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   errors,
  output int                   pending,
  output int                   checked,
  output int                   crashes
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint PAGE_TOTAL = longint'(BLOCKS) * longint'(BLOCK_PAGES);
  localparam logic [COUNT_W-1:0] COUNT_TOP = COUNT_W'((64'd1 << COUNT_BITS) - 64'd1);

  logic [CFG_W-1:0]   regs_now    [CFG_REGS];
  logic [COUNT_W-1:0] erase_tally [BLOCK_SPACE];
  logic [COUNT_W-1:0] prog_tally  [PAGE_SPACE];
  logic [COUNT_W-1:0] read_tally  [PAGE_SPACE];
  logic [COUNT_W-1:0] op_tally;
  logic               powered_down;
  fwft_result_t       due_results [$];

  function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] v);
    return (v >= COUNT_TOP) ? COUNT_TOP : v + 1'b1;
  endfunction

  // erase and program advance the operation count, then the crash point is tested
  function automatic logic hits_crash_point();
    op_tally = bump(op_tally);
    if (regs_now[REG_POWER_CUT] != '0 && op_tally >= regs_now[REG_POWER_CUT]) begin
      powered_down = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic fwft_result_t track_command(input fwft_op_t c);
    fwft_result_t       r;
    logic [COUNT_W-1:0] rc;
    logic [COUNT_W-1:0] pc;
    int unsigned        blk;
    int unsigned        pg;
    r   = '0;
    blk = 32'(c.block_index);
    pg  = 32'(c.page_index);
    if (powered_down) begin
      r.status = STATUS_INVALID;
    end else begin
      case (c.command)
        CMD_ERASE: begin
          if (hits_crash_point()) begin
            r.status      = STATUS_FAIL;
            r.crash_fired = 1'b1;
          end else if (longint'(blk) >= longint'(BLOCKS)) begin
            r.status = STATUS_FAIL;
          end else begin
            // a zero limit leaves the erase count untouched
            if (regs_now[REG_MAX_ERASE] != '0) begin
              erase_tally[blk] = bump(erase_tally[blk]);
              if (erase_tally[blk] > regs_now[REG_MAX_ERASE]) r.status = STATUS_FAIL;
            end
            r.wear_count = erase_tally[blk];
          end
        end
        CMD_PROGRAM: begin
          if (hits_crash_point()) begin
            r.status      = STATUS_FAIL;
            r.crash_fired = 1'b1;
          end else if (longint'(pg) >= PAGE_TOTAL) begin
            r.status = STATUS_FAIL;
          end else begin
            prog_tally[pg] = bump(prog_tally[pg]);
            if (regs_now[REG_MAX_PROG] != '0 && prog_tally[pg] > regs_now[REG_MAX_PROG])
              r.status = STATUS_FAIL;
            r.wear_count = prog_tally[pg];
          end
        end
        CMD_READ: begin
          if (longint'(pg) >= PAGE_TOTAL) begin
            r.status = STATUS_FAIL;
          end else begin
            read_tally[pg] = bump(read_tally[pg]);
            rc = read_tally[pg];
            pc = prog_tally[pg];
            if (regs_now[REG_GRAVE_PAGE] != '0 && pc > regs_now[REG_GRAVE_PAGE])
              r.ecc_grade = GRADE_FAIL;
            else if (regs_now[REG_ECC_FAIL] != '0 && rc >= regs_now[REG_ECC_FAIL])
              r.ecc_grade = GRADE_FAIL;
            else if (regs_now[REG_ECC_HIGH] != '0 && rc >= regs_now[REG_ECC_HIGH])
              r.ecc_grade = GRADE_HIGH;
            else if (regs_now[REG_ECC_MID] != '0 && rc >= regs_now[REG_ECC_MID])
              r.ecc_grade = GRADE_LOW;
            r.wear_count      = pc;
            r.page_read_count = rc;
          end
        end
        default: begin
        end
      endcase
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      // quiet after the first hundred
      if (errors <= 100) $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    fwft_result_t want;
    if (rst) begin
      foreach (regs_now[i]) regs_now[i] = '0;
      foreach (erase_tally[i]) erase_tally[i] = '0;
      foreach (prog_tally[i]) prog_tally[i] = '0;
      foreach (read_tally[i]) read_tally[i] = '0;
      op_tally     = '0;
      powered_down = 1'b0;
      due_results.delete();
      errors  = 0;
      checked = 0;
      crashes = 0;
    end else begin
      if (done) begin
        if (due_results.size() == 0) begin
          errors++;
          $error("result strobe with no command outstanding");
        end else begin
          want = due_results.pop_front();
          check_field("status", 32'(want.status), 32'(result.status));
          check_field("crash_fired", 32'(want.crash_fired), 32'(result.crash_fired));
          check_field("ecc_grade", 32'(want.ecc_grade), 32'(result.ecc_grade));
          check_field("wear_count", 32'(want.wear_count), 32'(result.wear_count));
          check_field("page_read_count", 32'(want.page_read_count),
                      32'(result.page_read_count));
          checked++;
        end
      end
      if (cfg_valid && cfg_ready && cfg_index < CFG_REGS) regs_now[cfg_index] = cfg_data;
      if (start && !busy) begin
        want = track_command(op);
        if (want.crash_fired) crashes++;
        due_results.push_back(want);
      end
    end
    pending = due_results.size();
  end

endmodule

/* verif/tb.sv */
// testbench top: drives the flash wear and fault tracker and gives the verdict
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fwft_pkg::*;

  localparam int BLOCKS      = 1024;
  localparam int BLOCK_PAGES = 64;
  localparam int COUNT_BITS  = 24;

  // index with no register behind it, writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  // reset sweep plus the time for the items, taken several times over
  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_PHASES = 5;
  localparam int PHASE_ITEMS   = 160;
  localparam int CRASH_ITEMS   = 60;
  localparam logic [CFG_W-1:0] REG_TOP = '1;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  fwft_op_t             op;
  logic                 done;
  fwft_result_t         result;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  int errors;
  int pending;
  int checked;
  int crashes;

  // stimulus bookkeeping
  int cycles;
  int items_sent;
  int ops_sent;
  int settings_used;
  int idle_pct;
  int blk_base;
  int pg_base;
  int pg_span;
  logic [CFG_W-1:0] next_regs [CFG_REGS];

  flash_wear_fault_tracker #(
    .BLOCKS      (BLOCKS),
    .BLOCK_PAGES (BLOCK_PAGES),
    .COUNT_BITS  (COUNT_BITS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .op        (op),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  fwft_tracker_check #(
    .BLOCKS      (BLOCKS),
    .BLOCK_PAGES (BLOCK_PAGES),
    .COUNT_BITS  (COUNT_BITS)
  ) chk (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .op        (op),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending),
    .checked   (checked),
    .crashes   (crashes)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run here
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: FAIL");
    $finish;
  end

  function automatic fwft_op_t mk(input cmd_t c, input int b, input int p);
    fwft_op_t o;
    o.command     = c;
    o.block_index = BLOCK_INDEX_W'(b);
    o.page_index  = PAGE_INDEX_W'(p);
    return o;
  endfunction

  // mostly a small pool of blocks and pages so the counters climb past the limits,
  // with some fully random addresses as noise
  function automatic fwft_op_t make_op();
    int   w;
    cmd_t c;
    w = $urandom_range(99);
    if (w < 25)      c = CMD_ERASE;
    else if (w < 55) c = CMD_PROGRAM;
    else if (w < 90) c = CMD_READ;
    else             c = CMD_COPY;
    if ($urandom_range(99) < 15)
      return mk(c, $urandom_range(BLOCK_SPACE - 1), $urandom_range(PAGE_SPACE - 1));
    return mk(c, blk_base + $urandom_range(15), pg_base + $urandom_range(pg_span - 1));
  endfunction

  // limits: off, small enough to be crossed, the top value, or anything
  function automatic logic [CFG_W-1:0] any_limit();
    case ($urandom_range(9))
      0, 1:       return '0;
      2, 3, 4, 5: return CFG_W'($urandom_range(1, 8));
      6:          return REG_TOP;
      default:    return CFG_W'($urandom_range(0, 24'hFFFFFF));
    endcase
  endfunction

  task automatic rest(input int n);
    logic [$bits(fwft_op_t)-1:0] noise;
    noise = $bits(fwft_op_t)'($urandom);
    @(negedge clk);
    start <= 1'b0;
    op    <= noise;
    repeat (n - 1) @(negedge clk);
  endtask

  // one start transfer, then maybe a burst of idle cycles
  task automatic send(input fwft_op_t c);
    @(negedge clk);
    start <= 1'b1;
    op    <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    if (c.command == CMD_ERASE || c.command == CMD_PROGRAM) ops_sent++;
    if ($urandom_range(99) < idle_pct) rest($urandom_range(1, 17));
  endtask

  // hold the sender until every outstanding result has come back
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // write all registers of next_regs, plus a stray write to the unused index
  task automatic load_regs();
    for (int i = 0; i <= CFG_REGS; i++) begin
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_index <= (i < CFG_REGS) ? CFG_IDX_W'(i) : REG_SPARE;
      cfg_data  <= (i < CFG_REGS) ? next_regs[i] : CFG_W'($urandom_range(0, 24'hFFFFFF));
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic new_pool();
    blk_base = $urandom_range(BLOCK_SPACE - 16);
    pg_span  = $urandom_range(4, 32);
    pg_base  = $urandom_range(PAGE_SPACE - pg_span);
  endtask

  initial begin
    rst           = 1'b1;
    start         = 1'b0;
    op            = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    items_sent    = 0;
    ops_sent      = 0;
    settings_used = 1;
    idle_pct      = 30;
    blk_base      = 0;
    pg_base       = 0;
    pg_span       = 4;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: erase counting off, no limits, no grading, no crash point;
    // address and field extremes (waits out the clearing sweep on busy)
    send(mk(CMD_ERASE, 0, 0));
    send(mk(CMD_ERASE, BLOCK_SPACE - 1, PAGE_SPACE - 1));
    send(mk(CMD_PROGRAM, 0, 0));
    send(mk(CMD_PROGRAM, BLOCK_SPACE - 1, PAGE_SPACE - 1));
    send(mk(CMD_READ, 0, 0));
    send(mk(CMD_READ, BLOCK_SPACE - 1, PAGE_SPACE - 1));
    send(mk(CMD_COPY, 0, 0));
    send(mk(CMD_COPY, BLOCK_SPACE - 1, PAGE_SPACE - 1));

    // small limits so that each wear limit and each ecc grade is crossed
    drain();
    next_regs[REG_MAX_ERASE]  = 24'd2;
    next_regs[REG_MAX_PROG]   = 24'd2;
    next_regs[REG_GRAVE_PAGE] = 24'd3;
    next_regs[REG_ECC_MID]    = 24'd1;
    next_regs[REG_ECC_HIGH]   = 24'd2;
    next_regs[REG_ECC_FAIL]   = 24'd3;
    next_regs[REG_POWER_CUT]  = REG_TOP;
    load_regs();
    repeat (3) send(mk(CMD_ERASE, 5, 0));
    repeat (4) send(mk(CMD_PROGRAM, 0, 7));
    // page programmed past the grave threshold reads as uncorrectable
    send(mk(CMD_READ, 0, 7));
    // read count walks through grades low, high and fail
    repeat (3) send(mk(CMD_READ, 0, 9));

    // random phases: first every register at its top value, then all off,
    // then random settings; the crash point stays out of reach
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain();
      foreach (next_regs[i]) begin
        if (ph == 0)      next_regs[i] = REG_TOP;
        else if (ph == 1) next_regs[i] = '0;
        else              next_regs[i] = any_limit();
      end
      if (ph >= 2) begin
        case ($urandom_range(2))
          0:       next_regs[REG_POWER_CUT] = '0;
          1:       next_regs[REG_POWER_CUT] = REG_TOP;
          default: next_regs[REG_POWER_CUT] =
                     CFG_W'($urandom_range(ops_sent + 5000, 24'hFFFFFF));
        endcase
      end
      load_regs();
      new_pool();
      case ($urandom_range(3))
        0:       idle_pct = 0;
        1:       idle_pct = 20;
        2:       idle_pct = 50;
        default: idle_pct = 80;
      endcase
      repeat (PHASE_ITEMS) send(make_op());
    end

    // last part, no idling: crash point a few operations ahead, so power loss fires
    // and every later command is refused as invalid
    drain();
    foreach (next_regs[i]) next_regs[i] = any_limit();
    next_regs[REG_POWER_CUT] = CFG_W'(ops_sent + $urandom_range(4, 16));
    load_regs();
    new_pool();
    idle_pct = 0;
    repeat (CRASH_ITEMS) send(make_op());

    drain();
    repeat (8) @(posedge clk);
    $display("summary: %0d commands under %0d register settings, %0d results compared",
             items_sent, settings_used, checked);
    $display("summary: %0d erase and program operations, power loss fired %0d time(s)",
             ops_sent, crashes);
    if (errors == 0 && pending == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

/* flash_wear_fault_tracker.f */
hw/rtl/fwft_pkg.sv
hw/rtl/fwft_wear_mem.sv
hw/rtl/flash_wear_fault_tracker.sv
hw/rtl/fwft_checker.sv
verif/fwft_tracker_check.sv
verif/tb.sv
